@@ sv/ipv4f_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 address filter table: shared package
// Table size, item layouts, operation and status codes, controller states
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ipv4f_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths fixed by the item formats
    localparam int FUNC_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;

    // Operation codes; the unused code behaves as a lookup
    localparam logic [FUNC_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] OP_DELETE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Input item
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] ip_addr;
    } ipv4f_req_t;

    // Result item
    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } ipv4f_resp_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } ipv4f_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } ipv4f_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } ipv4f_stat_t;

endpackage

@@ sv/ipv4f_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 address filter table: controller
// Sequences one item at a time: accept, scan every slot, then commit the
// table update and load the result register once it is free.
// ----------------------------------------------------------------------------
module ipv4f_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ipv4f_pkg::ipv4f_stat_t stat,
    output ipv4f_pkg::ipv4f_cmd_t  cmd
);
    import ipv4f_pkg::*;

    ipv4f_state_t state_reg;
    ipv4f_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (stat.scan_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
            end
            S_COMMIT: begin
                cmd.commit = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/ipv4f_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 address filter table: datapath
// Address memory with registered read, per-slot valid bits, scan counter,
// match and free-slot trackers, table update and the result register.
// ----------------------------------------------------------------------------
module ipv4f_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ipv4f_pkg::ipv4f_req_t  s_data,
    output ipv4f_pkg::ipv4f_resp_t m_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  ipv4f_pkg::ipv4f_cmd_t  cmd,
    output ipv4f_pkg::ipv4f_stat_t stat
);
    import ipv4f_pkg::*;

    // Address store, written only at commit, read once a cycle during a scan
    logic [ADDR_W-1:0]      mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;

    // Item under work
    ipv4f_req_t req_reg;

    // Scan pipeline
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              rd_live_reg;
    logic              rd_live_next;
    logic [ADDR_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_slot_reg;
    logic              rd_vbit_reg;
    logic              issue;
    logic [IDX_W-1:0]  rd_idx;

    // Trackers
    logic              found_reg;
    logic              found_next;
    logic [IDX_W-1:0]  match_reg;
    logic [IDX_W-1:0]  match_next;
    logic              free_found_reg;
    logic              free_found_next;
    logic [IDX_W-1:0]  free_reg;
    logic [IDX_W-1:0]  free_next;

    // Result register
    logic        m_valid_reg;
    logic        m_valid_next;
    ipv4f_resp_t resp_reg;
    ipv4f_resp_t resp_next;
    logic        wr_en;

    assign rd_idx = cnt_reg[IDX_W-1:0];
    assign issue  = cmd.scan && (cnt_reg < CNT_W'(TABLE_DEPTH));

    assign stat.scan_done = (cnt_reg == CNT_W'(TABLE_DEPTH)) && !rd_live_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = resp_reg;

    // Advance the scan counter and track the read in flight
    always_comb begin
        cnt_next     = cnt_reg;
        rd_live_next = issue;
        if (cmd.start) begin
            cnt_next = '0;
        end else if (issue) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // Compare the returned entry; keep the lowest match and lowest free slot
    always_comb begin
        found_next      = found_reg;
        match_next      = match_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        if (cmd.start) begin
            found_next      = 1'b0;
            free_found_next = 1'b0;
        end else if (rd_live_reg) begin
            if (rd_vbit_reg && (rd_data_reg == req_reg.ip_addr) && !found_reg) begin
                found_next = 1'b1;
                match_next = rd_slot_reg;
            end
            if (!rd_vbit_reg && !free_found_reg) begin
                free_found_next = 1'b1;
                free_next       = rd_slot_reg;
            end
        end
    end

    // Decide the table update and the result
    always_comb begin
        valid_next       = valid_reg;
        wr_en            = 1'b0;
        resp_next        = resp_reg;
        m_valid_next     = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.commit) begin
            m_valid_next     = 1'b1;
            resp_next.hit    = found_reg;
            resp_next.slot   = '0;
            resp_next.status = ST_NOT_FOUND;
            case (req_reg.func)
                OP_INSERT: begin
                    if (found_reg) begin
                        resp_next.slot   = SLOT_W'(match_reg);
                        resp_next.status = ST_PRESENT;
                    end else if (free_found_reg) begin
                        wr_en                = 1'b1;
                        valid_next[free_reg] = 1'b1;
                        resp_next.slot       = SLOT_W'(free_reg);
                        resp_next.status     = ST_DONE;
                    end else begin
                        resp_next.status = ST_FULL;
                    end
                end
                OP_DELETE: begin
                    if (found_reg) begin
                        valid_next[match_reg] = 1'b0;
                        resp_next.slot        = SLOT_W'(match_reg);
                        resp_next.status      = ST_DONE;
                    end
                end
                default: begin
                    if (found_reg) begin
                        resp_next.slot   = SLOT_W'(match_reg);
                        resp_next.status = ST_DONE;
                    end
                end
            endcase
        end
    end

    // Memory: write at commit, registered read during the scan
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[free_reg] <= req_reg.ip_addr;
        end
        if (issue) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // Hold the item and the scan payload
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_reg <= s_data;
        end
        if (issue) begin
            rd_slot_reg <= rd_idx;
            rd_vbit_reg <= valid_reg[rd_idx];
        end
        match_reg <= match_next;
        free_reg  <= free_next;
        resp_reg  <= resp_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            cnt_reg        <= '0;
            rd_live_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            cnt_reg        <= cnt_next;
            rd_live_reg    <= rd_live_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

endmodule

@@ sv/ipv4_address_filter_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 address filter table: top level
// A bounded set of IPv4 addresses with lookup, insert-if-absent and delete.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one item: func (0 lookup, 1 insert,
//   2 delete, 3 acts as lookup) and ip_addr. m_valid/m_ready/m_data return
//   one result per item: hit, slot and status (done, already present,
//   not found, table full).
//   Each item scans every slot of the address memory, one slot a cycle
//   through its single registered read port; the result is registered at
//   the commit after the last read returns, and the next item is taken
//   only once the controller is back in idle, so one item at a time.
//   The result register separates the two sides: a new item is accepted
//   and scanned while the previous result still waits; if the receiver
//   holds m_ready low, the block waits at the commit step until the
//   result register frees, with the table unchanged until then.
//   Reset clears all valid bits at once, so the table is empty straight
//   after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ipv4_address_filter_table (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ipv4f_pkg::ipv4f_req_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ipv4f_pkg::ipv4f_resp_t m_data
);
    import ipv4f_pkg::*;

    ipv4f_cmd_t  cmd;
    ipv4f_stat_t stat;

    // Sequencer
    ipv4f_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Table storage, scan and result
    ipv4f_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule
